### rtl/core/bpa_pkg.sv
// bpa_pkg: shared types and constants for the buddy page allocator
// no dependencies; used by the channel interfaces and the core
package bpa_pkg;

    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_RUN    = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_ZERO      = 2'd3
    } t_status;

endpackage

### rtl/core/bpa_if.sv
// bpa_req_if / bpa_rsp_if: valid/ready channels for requests and results
// depends on bpa_pkg
interface bpa_req_if;
    logic             valid;
    logic             ready;
    bpa_pkg::t_op     operation;
    logic [10:0]      page_count;
    logic [9:0]       page_index;

    modport source (output valid, output operation, output page_count,
                    output page_index, input ready);
    modport sink   (input valid, input operation, input page_count,
                    input page_index, output ready);
endinterface

interface bpa_rsp_if;
    logic             valid;
    logic             ready;
    logic [9:0]       first_page;
    logic [10:0]      block_pages;
    bpa_pkg::t_status status;

    modport source (output valid, output first_page, output block_pages,
                    output status, input ready);
    modport sink   (input valid, input first_page, input block_pages,
                    input status, output ready);
endinterface

### rtl/core/bpa_tree_mem.sv
// bpa_tree_mem: free-run tree storage, one write port and two registered read ports
// no dependencies
module bpa_tree_mem #(
    parameter int DEPTH = 2047,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/buddy_page_allocator_core.sv
// Buddy page allocator over a binary tree of PAGES pages held in one memory.
// After reset the tree is initialized by a pass that writes all 2*PAGES-1 nodes,
// during which no request is taken. An allocate makes one memory read per level on
// the way down and one read-modify-write per level back up; a free reads one node
// per level as it climbs to its block, then makes one read-modify-write per level
// up to the root. Zero counts, oversize requests and out-of-range frees finish
// without walking the tree. Each tree level waits on the registered memory read.
// Depends on bpa_pkg, bpa_if and bpa_tree_mem.
module buddy_page_allocator_core #(
    parameter int PAGES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpa_req_if.sink      i_in,
    bpa_rsp_if.source    o_out
);
    import bpa_pkg::*;

    localparam int LOG   = $clog2(PAGES);
    localparam int VW    = LOG + 1;
    localparam int NW    = LOG + 1;
    localparam int NODES = 2 * PAGES - 1;
    localparam int CW    = (VW > CNT_W) ? VW : CNT_W;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_ROOT = 7'b0000100,
        S_DOWN = 7'b0001000,
        S_UP   = 7'b0010000,
        S_FREE = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [NW-1:0]    r_x, n_x;
    logic [VW-1:0]    r_len, n_len;
    logic [LOG-1:0]   r_first, n_first;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [VW-1:0]    r_val, n_val;
    logic [NW-1:0]    r_init_addr, n_init_addr;
    logic [VW-1:0]    r_init_val, n_init_val;
    logic [LOG-1:0]   r_res_first, n_res_first;
    logic [VW-1:0]    r_res_pages, n_res_pages;
    t_status          r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_first, n_out_first;
    logic [CNT_W-1:0] r_out_pages, n_out_pages;
    t_status          r_out_status, n_out_status;

    logic             mem_we;
    logic [NW-1:0]    mem_waddr;
    logic [VW-1:0]    mem_wdata;
    logic [NW-1:0]    mem_ra;
    logic [NW-1:0]    mem_rb;
    logic [VW-1:0]    mem_da;
    logic [VW-1:0]    mem_db;

    bpa_tree_mem #(
        .DEPTH(NODES),
        .AW   (NW),
        .DW   (VW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr_a(mem_ra),
        .i_raddr_b(mem_rb),
        .o_rdata_a(mem_da),
        .o_rdata_b(mem_db)
    );

    function automatic logic [NW-1:0] sib(input logic [NW-1:0] x);
        sib = x[0] ? (x + NW'(1)) : (x - NW'(1));
    endfunction

    function automatic logic [NW-1:0] parent(input logic [NW-1:0] x);
        logic [NW-1:0] t;
        t = x - NW'(1);
        parent = t >> 1;
    endfunction

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.first_page  = r_out_first;
    assign o_out.block_pages = r_out_pages;
    assign o_out.status      = r_out_status;

    always_comb begin
        logic [NW:0]   a1;
        logic [NW:0]   a2;
        logic [NW-1:0] t;
        logic [VW-1:0] tlen;
        logic [LOG-1:0] tfirst;
        logic          take;
        logic [NW-1:0] p;
        logic [VW-1:0] plen;
        logic [VW-1:0] merged;

        n_state      = r_state;
        n_x          = r_x;
        n_len        = r_len;
        n_first      = r_first;
        n_cnt        = r_cnt;
        n_val        = r_val;
        n_init_addr  = r_init_addr;
        n_init_val   = r_init_val;
        n_res_first  = r_res_first;
        n_res_pages  = r_res_pages;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_first  = r_out_first;
        n_out_pages  = r_out_pages;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_x;
        mem_wdata    = '0;
        mem_ra       = r_x;
        mem_rb       = r_x;
        a1           = {1'b0, r_init_addr} + (NW+1)'(1);
        a2           = {1'b0, r_init_addr} + (NW+1)'(2);
        t            = r_x;
        tlen         = r_len;
        tfirst       = r_first;
        take         = 1'b0;
        p            = parent(r_x);
        plen         = r_len << 1;
        merged       = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                mem_we      = 1'b1;
                mem_waddr   = r_init_addr;
                mem_wdata   = r_init_val;
                n_init_addr = a1[NW-1:0];
                // last node of a level: the next level holds half the size
                if ((a2 & a1) == '0) begin
                    n_init_val = r_init_val >> 1;
                end
                if (r_init_addr == NW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.operation == OP_FREE) begin
                        if (32'(i_in.page_index) >= 32'(PAGES)) begin
                            n_res_first  = '0;
                            n_res_pages  = '0;
                            n_res_status = ST_NOT_ALLOC;
                            n_state      = S_FIN;
                        end else begin
                            n_x     = NW'(PAGES - 1 + int'(i_in.page_index));
                            n_len   = VW'(1);
                            n_first = LOG'(i_in.page_index);
                            mem_ra  = n_x;
                            n_state = S_FREE;
                        end
                    end else if (i_in.page_count == '0) begin
                        n_res_first  = '0;
                        n_res_pages  = '0;
                        n_res_status = ST_ZERO;
                        n_state      = S_FIN;
                    end else begin
                        n_cnt   = CW'(i_in.page_count);
                        mem_ra  = '0;
                        n_state = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (CW'(mem_da) < r_cnt) begin
                    n_res_first  = '0;
                    n_res_pages  = '0;
                    n_res_status = ST_NO_RUN;
                    n_state      = S_FIN;
                end else begin
                    n_x     = '0;
                    n_len   = VW'(PAGES);
                    n_first = '0;
                    mem_ra  = NW'(1);
                    mem_rb  = NW'(2);
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                // data holds the two children of r_x
                priority if (CW'(mem_da) >= r_cnt) begin
                    t      = (r_x << 1) + NW'(1);
                    tlen   = r_len >> 1;
                    tfirst = r_first;
                end else if (CW'(mem_db) >= r_cnt) begin
                    t      = (r_x << 1) + NW'(2);
                    tlen   = r_len >> 1;
                    tfirst = r_first + LOG'(r_len >> 1);
                end else begin
                    take = 1'b1;
                end
                if (!take && (32'(t) >= 32'(PAGES - 1))) begin
                    take = 1'b1;
                end
                n_x     = t;
                n_len   = tlen;
                n_first = tfirst;
                if (take) begin
                    mem_we       = 1'b1;
                    mem_waddr    = t;
                    mem_wdata    = '0;
                    n_val        = '0;
                    n_res_first  = tfirst;
                    n_res_pages  = tlen;
                    n_res_status = ST_OK;
                    if (t == '0) begin
                        n_state = S_FIN;
                    end else begin
                        mem_ra  = sib(t);
                        n_state = S_UP;
                    end
                end else begin
                    mem_ra = (t << 1) + NW'(1);
                    mem_rb = (t << 1) + NW'(2);
                end
            end
            S_UP: begin
                // merge r_val with its sibling into the parent
                if (r_val == r_len && mem_da == r_len) begin
                    merged = plen;
                end else begin
                    merged = (r_val > mem_da) ? r_val : mem_da;
                end
                mem_we    = 1'b1;
                mem_waddr = p;
                mem_wdata = merged;
                n_val     = merged;
                n_x       = p;
                n_len     = plen;
                if (p == '0) begin
                    n_state = S_FIN;
                end else begin
                    mem_ra = sib(p);
                end
            end
            S_FREE: begin
                if (mem_da == '0) begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_x;
                    mem_wdata    = r_len;
                    n_val        = r_len;
                    n_res_first  = r_first;
                    n_res_pages  = r_len;
                    n_res_status = ST_OK;
                    if (r_x == '0) begin
                        n_state = S_FIN;
                    end else begin
                        mem_ra  = sib(r_x);
                        n_state = S_UP;
                    end
                end else if (r_x == '0) begin
                    n_res_first  = '0;
                    n_res_pages  = '0;
                    n_res_status = ST_NOT_ALLOC;
                    n_state      = S_FIN;
                end else begin
                    n_x     = p;
                    n_len   = plen;
                    n_first = r_first & ~LOG'(plen - VW'(1));
                    mem_ra  = p;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_first  = IDX_W'(r_res_first);
                    n_out_pages  = CNT_W'(r_res_pages);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_init_val  <= VW'(PAGES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_init_val  <= n_init_val;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_len        <= n_len;
        r_first      <= n_first;
        r_cnt        <= n_cnt;
        r_val        <= n_val;
        r_res_first  <= n_res_first;
        r_res_pages  <= n_res_pages;
        r_res_status <= n_res_status;
        r_out_first  <= n_out_first;
        r_out_pages  <= n_out_pages;
        r_out_status <= n_out_status;
    end

endmodule

### rtl/core/bpa_checker.sv
// bpa_checker: port-level checks on the buddy page allocator core
// depends on bpa_pkg; bound to buddy_page_allocator_core below
module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  i_out_first,
    input logic [10:0] i_out_pages,
    input logic [1:0]  i_out_status
);
    import bpa_pkg::*;

    // a pending result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("result dropped before transfer");

    // one request at a time: ready drops after a request transfer
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");

    // errors report an empty block
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> i_out_first == '0 && i_out_pages == '0)
        else $error("error result carries a block");

    // a block that was handed out or freed is never empty
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_OK) |-> $onehot(i_out_pages))
        else $error("block size is not a power of two");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_first (o_out.first_page),
    .i_out_pages (o_out.block_pages),
    .i_out_status(o_out.status)
);

### tb/bpa_checker.sv
// bpa_tb_checker: watches request and result channels of the buddy page allocator,
// predicts each result from a private copy of the free-run tree and compares
// depends on bpa_pkg and bpa_if
`timescale 1ns / 1ps
module bpa_tb_checker #(
    parameter int PAGES = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bpa_req_if    req,
    bpa_rsp_if    rsp,
    output int    o_fail_count,
    output int    o_pending
);
    import bpa_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] first_page;
        logic [CNT_W-1:0] block_pages;
        t_status          status;
    } t_alloc_result;

    int unsigned   free_run [2*PAGES-1];
    t_alloc_result result_fifo [$];
    int            fails;

    assign o_fail_count = fails;
    assign o_pending    = result_fifo.size();

    task automatic reset_tree();
        for (int x = PAGES - 1; x < 2*PAGES - 1; x++) free_run[x] = 1;
        for (int x = PAGES - 2; x >= 0; x--) free_run[x] = 2 * free_run[2*x+1];
    endtask

    // recompute ancestors of node x whose size is len
    task automatic fix_ancestors(int x, int unsigned len);
        int unsigned l;
        int unsigned r;
        while (x > 0) begin
            x = (x - 1) / 2;
            len = len * 2;
            l = free_run[2*x+1];
            r = free_run[2*x+2];
            if (l == len/2 && r == len/2) free_run[x] = len;
            else free_run[x] = (l > r) ? l : r;
        end
    endtask

    function automatic t_alloc_result pack_res(longint f, longint s, t_status st);
        t_alloc_result res;
        res.first_page  = f[IDX_W-1:0];
        res.block_pages = s[CNT_W-1:0];
        res.status      = st;
        return res;
    endfunction

    task automatic predict_alloc(int unsigned n, output t_alloc_result res);
        int x;
        int unsigned len;
        x = 0;
        len = PAGES;
        if (n == 0) begin
            res = pack_res(0, 0, ST_ZERO);
        end else if (free_run[0] < n) begin
            res = pack_res(0, 0, ST_NO_RUN);
        end else begin
            while (x < PAGES - 1) begin
                if (free_run[2*x+1] >= n) x = 2*x + 1;
                else if (free_run[2*x+2] >= n) x = 2*x + 2;
                else break;
                len = len / 2;
            end
            free_run[x] = 0;
            fix_ancestors(x, len);
            res = pack_res(longint'(len) * (x + 1) - PAGES, len, ST_OK);
        end
    endtask

    task automatic predict_free(int unsigned p, output t_alloc_result res);
        int x;
        int unsigned len;
        len = 1;
        if (p >= PAGES) begin
            res = pack_res(0, 0, ST_NOT_ALLOC);
        end else begin
            x = PAGES - 1 + p;
            while (x > 0 && free_run[x] != 0) begin
                x = (x - 1) / 2;
                len = len * 2;
            end
            if (free_run[x] != 0) begin
                res = pack_res(0, 0, ST_NOT_ALLOC);
            end else begin
                free_run[x] = len;
                fix_ancestors(x, len);
                res = pack_res(longint'(len) * (x + 1) - PAGES, len, ST_OK);
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    initial begin
        fails = 0;
        reset_tree();
    end

    always @(posedge i_clk) begin
        t_alloc_result res;
        t_alloc_result want;
        if (i_rst_n) begin
            if (req.valid && req.ready) begin
                if (req.operation == OP_ALLOC) predict_alloc(req.page_count, res);
                else predict_free(req.page_index, res);
                result_fifo.push_back(res);
            end
            if (rsp.valid && rsp.ready) begin
                if (result_fifo.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    want = result_fifo.pop_front();
                    if (rsp.first_page !== want.first_page)
                        report_mismatch("first_page", rsp.first_page, want.first_page);
                    if (rsp.block_pages !== want.block_pages)
                        report_mismatch("block_pages", rsp.block_pages, want.block_pages);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                end
            end
        end
    end
endmodule

### tb/buddy_page_allocator_core_tb.sv
// buddy_page_allocator_core_tb: drives allocate and free requests with random idling
// on both channels; bpa_tb_checker predicts and compares results
// depends on bpa_pkg, bpa_if, buddy_page_allocator_core and bpa_tb_checker
`timescale 1ns / 1ps
module buddy_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam int PAGES = 1024;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   live_pages [$];

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    buddy_page_allocator_core #(.PAGES(PAGES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req),
        .o_out   (rsp)
    );

    bpa_tb_checker #(.PAGES(PAGES)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // remember a page inside each block reported OK so frees mostly hit live blocks
    always @(posedge i_clk) begin
        if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.block_pages != 0)
            live_pages.push_back(rsp.first_page + $urandom_range(rsp.block_pages - 1));
    end

    // valid stays high into the next transfer unless the sender idles
    task automatic send_item(t_op op, logic [10:0] cnt, logic [9:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.page_count <= cnt;
        req.page_index <= idx;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int k;
        int sel;
        logic [10:0] cnt;
        k = $urandom_range(99);
        if (k < 50) begin
            sel = $urandom_range(9);
            if (sel < 7) cnt = 11'($urandom_range(1, 16));
            else if (sel < 9) cnt = 11'($urandom_range(1, 256));
            else cnt = 11'($urandom);
            send_item(OP_ALLOC, cnt, 10'($urandom));
        end else if (k < 90 && live_pages.size() != 0) begin
            sel = $urandom_range(live_pages.size() - 1);
            send_item(OP_FREE, 11'($urandom), 10'(live_pages[sel]));
            live_pages.delete(sel);
        end else begin
            send_item(OP_FREE, 11'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.operation  = OP_ALLOC;
        req.page_count = '0;
        req.page_index = '0;
        rsp.ready      = 1'b0;
        send_idle_pct  = 20;
        recv_idle_pct  = 46;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and each special case
        send_item(OP_ALLOC, 11'd0, 10'h3ff);
        send_item(OP_ALLOC, 11'd1025, 10'd0);
        send_item(OP_ALLOC, 11'h7ff, 10'd0);
        send_item(OP_FREE, 11'd0, 10'd5);
        send_item(OP_ALLOC, 11'd1024, 10'd0);
        send_item(OP_ALLOC, 11'd1, 10'd0);
        send_item(OP_FREE, 11'h7ff, 10'd1023);
        send_item(OP_FREE, 11'd0, 10'd0);
        send_item(OP_ALLOC, 11'd1, 10'd0);
        send_item(OP_ALLOC, 11'd3, 10'd0);
        send_item(OP_ALLOC, 11'd512, 10'd0);
        send_item(OP_ALLOC, 11'd512, 10'd0);
        send_item(OP_FREE, 11'd0, 10'd6);
        send_item(OP_FREE, 11'd0, 10'd700);
        send_item(OP_FREE, 11'd0, 10'd0);
        send_item(OP_FREE, 11'd0, 10'd0);
        send_item(OP_ALLOC, 11'd1000, 10'd0);
        send_item(OP_ALLOC, 11'd1024, 10'd0);
        send_item(OP_FREE, 11'd0, 10'd1023);
        send_item(OP_ALLOC, 11'd2, 10'd0);
        send_item(OP_FREE, 11'd0, 10'd1);
        wait_drained();
        live_pages.delete();
        send_item(OP_FREE, 11'd0, 10'd512);

        for (int i = 0; i < 750; i++) begin
            if (i == 250) begin
                send_idle_pct = 46;
                recv_idle_pct = 20;
            end
            if (i == 500) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == 400) wait_drained();
            random_item();
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule

### buddy_page_allocator_core.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/bpa_tree_mem.sv
rtl/core/buddy_page_allocator_core.sv
rtl/core/bpa_checker.sv
tb/bpa_checker.sv
tb/buddy_page_allocator_core_tb.sv
